// ----- hw/rtl/mse_pkg.sv -----
// Morse symbol encoder package: symbol codes, queue entry type, character table.
// No dependencies; used by every module of the encoder.
package mse_pkg;

  localparam logic [1:0] SYM_SEP  = 2'd0;
  localparam logic [1:0] SYM_DOT  = 2'd1;
  localparam logic [1:0] SYM_DASH = 2'd2;

  localparam int unsigned CODE_MAX = 7;

  // One classified character: number of dots/dashes and the pattern,
  // left aligned (first symbol in the top bit, 1 = dash).
  typedef struct packed {
    logic [2:0]          len;
    logic [CODE_MAX-1:0] pat;
  } mse_code_t;

  // Build an entry from a right-aligned pattern literal.
  function automatic mse_code_t mk(input logic [2:0] n, input logic [CODE_MAX-1:0] p);
    mse_code_t r;
    r.len = n;
    r.pat = p << (3'(CODE_MAX) - n);
    return r;
  endfunction

  function automatic mse_code_t lookup(input logic [7:0] c_in);
    logic [7:0] c;
    mse_code_t  r;
    c = c_in;
    if (c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end
    case (c)
      "A":     r = mk(3'd2, 7'b01);
      "B":     r = mk(3'd4, 7'b1000);
      "C":     r = mk(3'd4, 7'b1010);
      "D":     r = mk(3'd3, 7'b100);
      "E":     r = mk(3'd1, 7'b0);
      "F":     r = mk(3'd4, 7'b0010);
      "G":     r = mk(3'd3, 7'b110);
      "H":     r = mk(3'd4, 7'b0000);
      "I":     r = mk(3'd2, 7'b00);
      "J":     r = mk(3'd4, 7'b0111);
      "K":     r = mk(3'd3, 7'b101);
      "L":     r = mk(3'd4, 7'b0100);
      "M":     r = mk(3'd2, 7'b11);
      "N":     r = mk(3'd2, 7'b10);
      "O":     r = mk(3'd3, 7'b111);
      "P":     r = mk(3'd4, 7'b0110);
      "Q":     r = mk(3'd4, 7'b1101);
      "R":     r = mk(3'd3, 7'b010);
      "S":     r = mk(3'd3, 7'b000);
      "T":     r = mk(3'd1, 7'b1);
      "U":     r = mk(3'd3, 7'b001);
      "V":     r = mk(3'd4, 7'b0001);
      "W":     r = mk(3'd3, 7'b011);
      "X":     r = mk(3'd4, 7'b1001);
      "Y":     r = mk(3'd4, 7'b1011);
      "Z":     r = mk(3'd4, 7'b1100);
      "0":     r = mk(3'd5, 7'b11111);
      "1":     r = mk(3'd5, 7'b01111);
      "2":     r = mk(3'd5, 7'b00111);
      "3":     r = mk(3'd5, 7'b00011);
      "4":     r = mk(3'd5, 7'b00001);
      "5":     r = mk(3'd5, 7'b00000);
      "6":     r = mk(3'd5, 7'b10000);
      "7":     r = mk(3'd5, 7'b11000);
      "8":     r = mk(3'd5, 7'b11100);
      "9":     r = mk(3'd5, 7'b11110);
      ".":     r = mk(3'd6, 7'b010101);
      ",":     r = mk(3'd6, 7'b110011);
      ":":     r = mk(3'd6, 7'b111000);
      "?":     r = mk(3'd6, 7'b001100);
      "-":     r = mk(3'd6, 7'b100001);
      ";":     r = mk(3'd6, 7'b101010);
      8'h22:   r = mk(3'd6, 7'b010010);  // double quote
      "+":     r = mk(3'd5, 7'b01010);
      "/":     r = mk(3'd5, 7'b10010);
      "&":     r = mk(3'd5, 7'b01000);
      "$":     r = mk(3'd7, 7'b0001001);
      "@":     r = mk(3'd6, 7'b011010);
      "=":     r = mk(3'd5, 7'b10001);
      default: r = mk(3'd0, 7'b0);       // space, end byte, anything unknown
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/mse_front.sv -----
// Morse encoder front end: takes a character transaction and classifies it.
// Depends on mse_pkg.
module mse_front (
  input  logic              start,
  input  logic [7:0]        char_code,
  input  logic              queue_full,
  output logic              busy,
  output logic              push,
  output mse_pkg::mse_code_t entry
);
  import mse_pkg::*;

  assign busy  = queue_full;
  assign push  = start && !queue_full;
  assign entry = lookup(char_code);

endmodule

// ----- hw/rtl/mse_fifo.sv -----
// Morse encoder queue between front end and symbol sequencer.
// Depends on mse_pkg.
module mse_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mse_pkg::mse_code_t wdata,
  input  logic               pop,
  output mse_pkg::mse_code_t rdata,
  output logic               full,
  output logic               nonempty
);
  import mse_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mse_code_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue underflow");
`endif

endmodule

// ----- hw/rtl/mse_back.sv -----
// Morse encoder back end: plays one queued code as separator then dots/dashes.
// Depends on mse_pkg.
module mse_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  mse_pkg::mse_code_t q_data,
  output logic               pop,
  output logic               symbol_valid,
  output logic [1:0]         symbol,
  output logic               last_symbol
);
  import mse_pkg::*;

  logic                active;
  logic [2:0]          len;
  logic [CODE_MAX-1:0] pat;
  logic [2:0]          idx;
  logic                at_end;

  assign at_end = (idx == len);
  assign pop    = q_nonempty && (!active || at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      symbol_valid <= 1'b0;
    end else begin
      symbol_valid <= active;
      if (active) begin
        if (idx == '0) begin
          symbol <= SYM_SEP;
        end else begin
          symbol <= pat[CODE_MAX-1] ? SYM_DASH : SYM_DOT;
          pat    <= pat << 1;
        end
        last_symbol <= at_end;
        idx         <= idx + 1'b1;
        if (at_end) begin
          active <= 1'b0;
        end
      end
      if (pop) begin
        active <= 1'b1;
        len    <= q_data.len;
        pat    <= q_data.pat;
        idx    <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
      symbol_valid && !last_symbol |=> symbol_valid && symbol != SYM_SEP)
    else $error("symbol run broken");
  a_sep_opens_run: assert property (@(posedge clk) disable iff (rst)
      $past(symbol_valid) && !$past(last_symbol) && symbol_valid |-> symbol != SYM_SEP)
    else $error("separator inside a run");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst) active |-> idx <= len)
    else $error("sequencer index past code length");
`endif

endmodule

// ----- hw/rtl/morse_symbol_encoder.sv -----
// Morse symbol encoder top level: front end, queue and symbol sequencer.
// Depends on mse_pkg, mse_front, mse_fifo, mse_back.
//
// Usage:
//   Input channel: drive char_code and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy is high only
//   while the internal queue is full.
//   Output channel: each symbol appears on symbol / last_symbol for exactly
//   one cycle with symbol_valid high. symbol is 0 separator, 1 dot, 2 dash.
//   Every character gives a separator followed by its code; last_symbol
//   marks the final symbol of the run. Space, end byte 0 and characters
//   without a code give the separator alone.
// Path: a character taken into an empty, idle block is written to the queue,
//   popped into the sequencer, then its separator is registered on the outputs.
// Throughput: the sequencer plays one symbol per cycle, and a character gives
//   1 + code length symbols (1 to 8). Runs of consecutive characters follow
//   each other without gaps; the queue of QUEUE_DEPTH entries lets the sender
//   run ahead of the sequencer by that many characters.
// Reset: synchronous on rst; queue and sequencer empty, no symbol pending.
// The receiver cannot stall: symbols are emitted as soon as they are ready.
module morse_symbol_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] char_code,
  output logic       busy,
  output logic       symbol_valid,
  output logic [1:0] symbol,
  output logic       last_symbol
);
  import mse_pkg::*;

  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_nonempty;
  mse_code_t push_entry;
  mse_code_t head_entry;

  // Classify the incoming character into a code length and pattern.
  mse_front u_front (
    .start      (start),
    .char_code  (char_code),
    .queue_full (q_full),
    .busy       (busy),
    .push       (push),
    .entry      (push_entry)
  );

  // Decouples acceptance from symbol playback.
  mse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (push_entry),
    .pop      (pop),
    .rdata    (head_entry),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // One symbol per cycle, registered outputs.
  mse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_data       (head_entry),
    .pop          (pop),
    .symbol_valid (symbol_valid),
    .symbol       (symbol),
    .last_symbol  (last_symbol)
  );

endmodule

// ----- dv/tb_morse_symbol_encoder.sv -----
// Testbench for morse_symbol_encoder: directed and random text bytes with random
// sender gaps, each symbol checked against an in-bench Morse table.
// Depends on mse_pkg and the morse_symbol_encoder RTL.
module tb_morse_symbol_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  // One expected symbol of a character's run.
  typedef struct packed {
    logic [1:0] sym;
    logic       last;
  } morse_sym_t;

  // Tracks the symbols still owed by accepted characters, in order.
  class morse_run_scoreboard;
    morse_sym_t owed_symbols[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Dots and dashes of a character; empty when it has no code.
    function automatic string dot_dash_pattern(logic [7:0] ch);
      logic [7:0] c;
      c = ch;
      if (c >= "a" && c <= "z") c = c ^ 8'h20;  // fold case
      case (c)
        "A": return ".-";     "B": return "-...";   "C": return "-.-.";
        "D": return "-..";    "E": return ".";      "F": return "..-.";
        "G": return "--.";    "H": return "....";   "I": return "..";
        "J": return ".---";   "K": return "-.-";    "L": return ".-..";
        "M": return "--";     "N": return "-.";     "O": return "---";
        "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
        "S": return "...";    "T": return "-";      "U": return "..-";
        "V": return "...-";   "W": return ".--";    "X": return "-..-";
        "Y": return "-.--";   "Z": return "--..";
        "0": return "-----";  "1": return ".----";  "2": return "..---";
        "3": return "...--";  "4": return "....-";  "5": return ".....";
        "6": return "-....";  "7": return "--...";  "8": return "---..";
        "9": return "----.";
        ".": return ".-.-.-"; ",": return "--..--"; ":": return "---...";
        "?": return "..--.."; "-": return "-....-"; ";": return "-.-.-.";
        8'h22: return ".-..-.";  // double quote
        "+": return ".-.-.";  "/": return "-..-.";  "&": return ".-...";
        "$": return "...-..-";
        "@": return ".--.-."; "=": return "-...-";
        default: return "";
      endcase
    endfunction

    // Accepted input transaction: queue separator plus code symbols.
    function void note_char(logic [7:0] ch);
      string      pat;
      morse_sym_t e;
      pat = dot_dash_pattern(ch);
      e.sym  = SYM_SEP;
      e.last = (pat.len() == 0);
      owed_symbols.push_back(e);
      for (int k = 0; k < pat.len(); k++) begin
        e.sym  = (pat[k] == ".") ? SYM_DOT : SYM_DASH;
        e.last = (k == pat.len() - 1);
        owed_symbols.push_back(e);
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Output transaction: compare against the oldest owed symbol.
    task check_symbol(logic [1:0] sym, logic last);
      morse_sym_t e;
      if (owed_symbols.size() == 0) begin
        report($sformatf("unexpected symbol %0d last %0d", sym, last));
      end else begin
        e = owed_symbols.pop_front();
        if (sym !== e.sym)
          report($sformatf("symbol got %0d want %0d", sym, e.sym));
        if (last !== e.last)
          report($sformatf("last_symbol got %0d want %0d", last, e.last));
      end
    endtask
  endclass

  localparam int WATCHDOG_LIMIT = 400;  // idle cycles in a row before the watchdog fires
  localparam int RANDOM_ITEMS   = 260;
  localparam string PUNCT_SET   = ".,:?-;\"+/&$@=";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic       busy;
  logic       symbol_valid;
  logic [1:0] symbol;
  logic       last_symbol;

  morse_run_scoreboard sb = new();
  int idle_cycles = 0;
  bit burst_mode = 1'b0;  // stretches with back-to-back transactions

  morse_symbol_encoder DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .char_code   (char_code),
    .busy        (busy),
    .symbol_valid(symbol_valid),
    .symbol      (symbol),
    .last_symbol (last_symbol)
  );

  always #6 clk = ~clk;

  // Monitor. Runs right after the edge, before the DUT's nonblocking updates
  // land, so every signal read here holds its pre-edge value. The input is
  // noted before the output check so a same-edge pair stays in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_char(char_code);
      if (symbol_valid) sb.check_symbol(symbol, last_symbol);
      if ((start && !busy) || symbol_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      // Nothing moving for too long: the block has hung.
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Sends one character after a gap. start is left high on a zero gap so
  // consecutive transactions go back to back with a single NBA per step.
  task send_char(logic [7:0] ch);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start     <= 1'b0;
      char_code <= 8'($urandom);  // junk while idle must be ignored
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    char_code <= ch;
    // Taken at the first edge that sees busy low.
    do @(posedge clk); while (busy);
  endtask

  // Mostly encodable characters, the rest space, end byte and any byte.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        c = 8'("A" + $urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = c | 8'h20;  // lowercase half the time
      end
      3:       c = 8'("0" + $urandom_range(0, 9));
      4, 5:    c = PUNCT_SET[$urandom_range(0, PUNCT_SET.len() - 1)];
      6:       c = $urandom_range(0, 1) ? 8'h20 : 8'h00;
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  initial begin
    // Directed part: byte extremes, space, longest code, case folding (y
    // included), letter/digit ends, every punctuation mark, unknown bytes.
    static logic [7:0] directed[] = '{
      8'h00, 8'hFF, " ", "$", "y", "Y", "a", "z", "E", "T", "0", "9",
      ".", ",", ":", "?", "-", ";", 8'h22, "+", "/", "&", "@", "=",
      8'h80, "#"
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      burst_mode = (i >= 18);  // tail of the list goes back to back
      send_char(directed[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_char(pick_char());
    end
    start <= 1'b0;

    // Drain, then give the sequencer time to show any stray symbol.
    while (sb.owed_symbols.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed_symbols.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- morse_symbol_encoder.f -----
hw/rtl/mse_pkg.sv
hw/rtl/mse_front.sv
hw/rtl/mse_fifo.sv
hw/rtl/mse_back.sv
hw/rtl/morse_symbol_encoder.sv
dv/tb_morse_symbol_encoder.sv
